// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files of the kana text normalizer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/knt_pkg.sv =====
// Package with the types and constants shared by the kana text normalizer modules.
package knt_pkg;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW = $clog2(FIFO_DEPTH);
    localparam int CP_W = 21;
    localparam logic [4:0] MAX_BYTES = 5'd16;

    typedef struct packed {
        logic            v0;
        logic [CP_W-1:0] cp0;
        logic            v1;
        logic [CP_W-1:0] cp1;
        logic            last;
        logic            err;
    } tok_t;

endpackage

// ===== hw/rtl/knt_front.sv =====
// Front part: input whitespace trimming and UTF-8 decoding into codepoint transfers.
module knt_front import knt_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // in_byte
    input  logic       s_tlast,   // text_last
    output logic       push,
    output tok_t       push_tok,
    input  logic       full
);

    typedef struct packed {
        logic            err;
        logic [1:0]      rem;
        logic [CP_W-1:0] acc;
        logic            v;
        logic [CP_W-1:0] cp;
    } dec_t;

    function automatic dec_t dec_step(dec_t s, logic [7:0] b);
        dec_t r;
        r = s;
        r.v = 1'b0;
        r.cp = '0;
        if (s.err)
        begin
            r.err = 1'b1;
        end
        else if (s.rem != 2'd0)
        begin
            r.acc = {s.acc[14:0], b[5:0]};
            r.rem = s.rem - 2'd1;
            if (r.rem == 2'd0)
            begin
                r.v = 1'b1;
                r.cp = r.acc;
            end
        end
        else if (!b[7])
        begin
            r.v = 1'b1;
            r.cp = {13'd0, b};
        end
        else if (b[7:5] == 3'b110)
        begin
            r.acc = {16'd0, b[4:0]};
            r.rem = 2'd1;
        end
        else if (b[7:4] == 4'b1110)
        begin
            r.acc = {17'd0, b[3:0]};
            r.rem = 2'd2;
        end
        else if (b[7:3] == 5'b11110)
        begin
            r.acc = {18'd0, b[2:0]};
            r.rem = 2'd3;
        end
        else
        begin
            r.err = 1'b1;
        end
        return r;
    endfunction

    logic            seen_reg, seen_next;
    logic            sp_reg, sp_next;
    logic            err_reg, err_next;
    logic [1:0]      rem_reg, rem_next;
    logic [CP_W-1:0] acc_reg, acc_next;

    dec_t s0, s1, s2, sn;
    logic ws, errf, acc_in;

    assign s_tready = !full;
    assign acc_in = s_tvalid && s_tready;
    assign push = acc_in;

    always_comb
    begin
        ws = (s_tdata == 8'h20) || (s_tdata == 8'h09) || (s_tdata == 8'h0A)
            || (s_tdata == 8'h0D);
        s0 = '{err: err_reg, rem: rem_reg, acc: acc_reg, v: 1'b0, cp: '0};
        s1 = sp_reg ? dec_step(s0, 8'h20) : s0;
        s2 = dec_step(s1, s_tdata);
        sn = ws ? s0 : s2;
        errf = sn.err || (s_tlast && (sn.rem != 2'd0));
        push_tok.v0 = !ws && sp_reg && s1.v && !errf;
        push_tok.cp0 = s1.cp;
        push_tok.v1 = !ws && s2.v && !errf;
        push_tok.cp1 = s2.cp;
        push_tok.last = s_tlast;
        push_tok.err = errf;
        if (ws)
        begin
            seen_next = seen_reg;
            sp_next = sp_reg || seen_reg;
        end
        else
        begin
            seen_next = 1'b1;
            sp_next = 1'b0;
        end
        err_next = errf;
        rem_next = sn.rem;
        acc_next = sn.acc;
        if (s_tlast)
        begin
            seen_next = 1'b0;
            sp_next = 1'b0;
            err_next = 1'b0;
            rem_next = 2'd0;
            acc_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= 1'b0;
            sp_reg <= 1'b0;
            err_reg <= 1'b0;
            rem_reg <= 2'd0;
            acc_reg <= '0;
        end
        else if (acc_in)
        begin
            seen_reg <= seen_next;
            sp_reg <= sp_next;
            err_reg <= err_next;
            rem_reg <= rem_next;
            acc_reg <= acc_next;
        end
    end

endmodule

// ===== hw/rtl/knt_fifo.sv =====
// Short queue of decoded transfers between the front and back parts.
module knt_fifo import knt_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  tok_t push_tok,
    output logic full,
    input  logic pop,
    output logic nonempty,
    output tok_t pop_tok
);

    tok_t              mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_reg, rd_reg;
    logic [FIFO_AW:0]   cnt_reg;

    assign full = (cnt_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign nonempty = (cnt_reg != '0);
    assign pop_tok = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_tok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
        end
    end

endmodule

// ===== hw/rtl/knt_back.sv =====
// Back part: kana mapping, voicing merge, punctuation, dots, spacing and UTF-8 encoding.
module knt_back import knt_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       nonempty,
    input  tok_t       pop_tok,
    output logic       pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte
    output logic       m_tlast,   // text_end
    output logic [2:0] m_tuser    // byte_present, run_last, bad_utf8
);

    typedef enum logic [2:0] {PH_IDLE, PH_C0, PH_C1, PH_FIN, PH_END} phase_t;

    typedef struct packed {
        logic [1:0]      dots;
        logic            ell;
        logic            av;
        logic [CP_W-1:0] a;
        logic            bv;
        logic [CP_W-1:0] b;
    } rel_t;

    function automatic logic is_ws(logic [CP_W-1:0] c);
        return (c == 21'h20) || (c == 21'h09) || (c == 21'h0A) || (c == 21'h0D);
    endfunction

    function automatic logic [15:0] half_kana(logic [5:0] i);
        logic [15:0] r;
        case (i)
            6'd0: r = 16'h30F2;  6'd1: r = 16'h30A1;  6'd2: r = 16'h30A3;
            6'd3: r = 16'h30A5;  6'd4: r = 16'h30A7;  6'd5: r = 16'h30A9;
            6'd6: r = 16'h30E3;  6'd7: r = 16'h30E5;  6'd8: r = 16'h30E7;
            6'd9: r = 16'h30C3;  6'd10: r = 16'h30FC; 6'd11: r = 16'h30A2;
            6'd12: r = 16'h30A4; 6'd13: r = 16'h30A6; 6'd14: r = 16'h30A8;
            6'd15: r = 16'h30AA; 6'd16: r = 16'h30AB; 6'd17: r = 16'h30AD;
            6'd18: r = 16'h30AF; 6'd19: r = 16'h30B1; 6'd20: r = 16'h30B3;
            6'd21: r = 16'h30B5; 6'd22: r = 16'h30B7; 6'd23: r = 16'h30B9;
            6'd24: r = 16'h30BB; 6'd25: r = 16'h30BD; 6'd26: r = 16'h30BF;
            6'd27: r = 16'h30C1; 6'd28: r = 16'h30C4; 6'd29: r = 16'h30C6;
            6'd30: r = 16'h30C8; 6'd31: r = 16'h30CA; 6'd32: r = 16'h30CB;
            6'd33: r = 16'h30CC; 6'd34: r = 16'h30CD; 6'd35: r = 16'h30CE;
            6'd36: r = 16'h30CF; 6'd37: r = 16'h30D2; 6'd38: r = 16'h30D5;
            6'd39: r = 16'h30D8; 6'd40: r = 16'h30DB; 6'd41: r = 16'h30DE;
            6'd42: r = 16'h30DF; 6'd43: r = 16'h30E0; 6'd44: r = 16'h30E1;
            6'd45: r = 16'h30E2; 6'd46: r = 16'h30E4; 6'd47: r = 16'h30E6;
            6'd48: r = 16'h30E8; 6'd49: r = 16'h30E9; 6'd50: r = 16'h30EA;
            6'd51: r = 16'h30EB; 6'd52: r = 16'h30EC; 6'd53: r = 16'h30ED;
            6'd54: r = 16'h30EF; 6'd55: r = 16'h30F3;
            default: r = 16'h0000;
        endcase
        return r;
    endfunction

    function automatic logic [CP_W-1:0] kana_map(logic [CP_W-1:0] c);
        logic [CP_W-1:0] d;
        d = c - 21'hFF66;
        if ((c >= 21'h3041) && (c <= 21'h3096))
        begin
            return c + 21'h60;
        end
        else if (c == 21'h309D)
        begin
            return 21'h30FD;
        end
        else if (c == 21'h309E)
        begin
            return 21'h30FE;
        end
        else if ((c >= 21'hFF66) && (c <= 21'hFF9D))
        begin
            return {5'd0, half_kana(d[5:0])};
        end
        return c;
    endfunction

    function automatic logic is_mark(logic [CP_W-1:0] c);
        return (c == 21'h3099) || (c == 21'h309A) || (c == 21'hFF9E) || (c == 21'hFF9F);
    endfunction

    function automatic logic [CP_W-1:0] voice(logic [CP_W-1:0] k, logic [CP_W-1:0] mk);
        logic hbase;
        hbase = (k == 21'h30CF) || (k == 21'h30D2) || (k == 21'h30D5)
            || (k == 21'h30D8) || (k == 21'h30DB);
        if ((mk == 21'h3099) || (mk == 21'hFF9E))
        begin
            if (k == 21'h30A6)
            begin
                return 21'h30F4;
            end
            if ((k >= 21'h30AB) && (k <= 21'h30C1) && k[0])
            begin
                return k + 21'd1;
            end
            if ((k == 21'h30C4) || (k == 21'h30C6) || (k == 21'h30C8) || hbase)
            begin
                return k + 21'd1;
            end
            if ((k >= 21'h30EF) && (k <= 21'h30F2))
            begin
                return k + 21'd8;
            end
            return k;
        end
        if (hbase)
        begin
            return k + 21'd2;
        end
        return k;
    endfunction

    function automatic logic [CP_W-1:0] punct(logic [CP_W-1:0] c);
        logic [CP_W-1:0] r;
        case (c)
            21'hFF01: r = 21'h21;
            21'hFF1F: r = 21'h3F;
            21'hFF0C, 21'hFF64: r = 21'h3001;
            21'hFF0E, 21'hFF61: r = 21'h3002;
            21'hFF62: r = 21'h300C;
            21'hFF63: r = 21'h300D;
            21'h3000: r = 21'h20;
            default: r = c;
        endcase
        return r;
    endfunction

    function automatic rel_t release_cp(logic [CP_W-1:0] c, logic [1:0] dots, logic ell);
        rel_t r;
        logic [CP_W-1:0] p;
        p = punct(c);
        r = '{dots: dots, ell: ell, av: 1'b0, a: '0, bv: 1'b0, b: '0};
        if (p == 21'h2E)
        begin
            r.ell = 1'b0;
            if (dots == 2'd2)
            begin
                r.av = 1'b1;
                r.a = 21'h2026;
                r.dots = 2'd0;
            end
            else
            begin
                r.dots = dots + 2'd1;
            end
        end
        else
        begin
            r.av = (dots != 2'd0);
            r.a = (dots == 2'd2) ? 21'h2026 : 21'h2E;
            r.dots = 2'd0;
            if (p == 21'h2026)
            begin
                r.bv = !ell;
                r.ell = !ell;
            end
            else
            begin
                r.bv = 1'b1;
                r.ell = 1'b0;
            end
            r.b = p;
        end
        return r;
    endfunction

    function automatic logic [1:0] enc_last(logic [CP_W-1:0] c);
        if (c <= 21'h7F)
        begin
            return 2'd0;
        end
        else if (c <= 21'h7FF)
        begin
            return 2'd1;
        end
        else if (c <= 21'hFFFF)
        begin
            return 2'd2;
        end
        return 2'd3;
    endfunction

    function automatic logic [7:0] enc_byte(logic [CP_W-1:0] c, logic [1:0] k);
        logic [7:0] r;
        case ({enc_last(c), k})
            4'b0000: r = c[7:0];
            4'b0100: r = {3'b110, c[10:6]};
            4'b0101: r = {2'b10, c[5:0]};
            4'b1000: r = {4'b1110, c[15:12]};
            4'b1001: r = {2'b10, c[11:6]};
            4'b1010: r = {2'b10, c[5:0]};
            4'b1100: r = {5'b11110, c[20:18]};
            4'b1101: r = {2'b10, c[17:12]};
            4'b1110: r = {2'b10, c[11:6]};
            4'b1111: r = {2'b10, c[5:0]};
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    phase_t          phase_reg;
    tok_t            tok_reg;
    logic [CP_W-1:0] held_reg;
    logic            held_v_reg;
    logic [1:0]      dots_reg;
    logic            ell_reg;
    logic            any_reg;
    logic            sp_reg;
    logic [1:0]      ev_v_reg;
    logic [CP_W-1:0] ev0_reg, ev1_reg;
    logic [1:0]      bidx_reg;
    logic            stage_v_reg;
    logic [7:0]      stage_reg;
    logic [4:0]      cnt_reg;
    logic            o_v_reg;
    logic [7:0]      o_byte_reg;
    logic [2:0]      o_user_reg;
    logic            o_last_reg;

    logic            go;
    logic [CP_W-1:0] cin, mapped, voiced;
    logic            merge;
    rel_t            rel;
    logic [CP_W-1:0] fl_cp;
    logic            fl_v;

    assign go = !o_v_reg || m_tready;
    assign pop = go && !ev_v_reg[0] && (phase_reg == PH_IDLE) && nonempty;
    assign m_tvalid = o_v_reg;
    assign m_tdata = o_byte_reg;
    assign m_tuser = o_user_reg;
    assign m_tlast = o_last_reg;

    always_comb
    begin
        cin = (phase_reg == PH_C0) ? tok_reg.cp0 : tok_reg.cp1;
        mapped = kana_map(cin);
        voiced = voice(held_reg, mapped);
        merge = held_v_reg && is_mark(mapped) && (voiced != held_reg);
        if (held_v_reg)
        begin
            rel = release_cp(held_reg, dots_reg, ell_reg);
        end
        else
        begin
            rel = '{dots: dots_reg, ell: ell_reg, av: 1'b0, a: '0, bv: 1'b0, b: '0};
        end
        fl_v = rel.bv || (rel.dots != 2'd0);
        fl_cp = rel.bv ? rel.b : ((rel.dots == 2'd2) ? 21'h2026 : 21'h2E);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            tok_reg <= '0;
            held_reg <= '0;
            held_v_reg <= 1'b0;
            dots_reg <= 2'd0;
            ell_reg <= 1'b0;
            any_reg <= 1'b0;
            sp_reg <= 1'b0;
            ev_v_reg <= 2'b00;
            ev0_reg <= '0;
            ev1_reg <= '0;
            bidx_reg <= 2'd0;
            stage_v_reg <= 1'b0;
            stage_reg <= 8'h00;
            cnt_reg <= 5'd0;
            o_v_reg <= 1'b0;
            o_byte_reg <= 8'h00;
            o_user_reg <= 3'b000;
            o_last_reg <= 1'b0;
        end
        else if (go)
        begin
            o_v_reg <= 1'b0;
            if (ev_v_reg[0])
            begin
                if (is_ws(ev0_reg) || !sp_reg)
                begin
                    if (is_ws(ev0_reg))
                    begin
                        sp_reg <= sp_reg || any_reg;
                    end
                    if (is_ws(ev0_reg) || (bidx_reg == enc_last(ev0_reg)))
                    begin
                        ev0_reg <= ev1_reg;
                        ev_v_reg <= {1'b0, ev_v_reg[1]};
                        bidx_reg <= 2'd0;
                    end
                    else
                    begin
                        bidx_reg <= bidx_reg + 2'd1;
                    end
                end
                else
                begin
                    sp_reg <= 1'b0;
                end
                if (!is_ws(ev0_reg) && (cnt_reg < MAX_BYTES))
                begin
                    if (!sp_reg && (bidx_reg == enc_last(ev0_reg)))
                    begin
                        any_reg <= 1'b1;
                    end
                    stage_reg <= sp_reg ? 8'h20 : enc_byte(ev0_reg, bidx_reg);
                    stage_v_reg <= 1'b1;
                    cnt_reg <= cnt_reg + 5'd1;
                    if (stage_v_reg)
                    begin
                        o_v_reg <= 1'b1;
                        o_byte_reg <= stage_reg;
                        o_user_reg <= 3'b001;
                        o_last_reg <= 1'b0;
                    end
                end
                else if (!is_ws(ev0_reg) && !sp_reg && (bidx_reg == enc_last(ev0_reg)))
                begin
                    any_reg <= 1'b1;
                end
            end
            else
            begin
                case (phase_reg)
                    PH_IDLE:
                    begin
                        if (nonempty)
                        begin
                            tok_reg <= pop_tok;
                            phase_reg <= PH_C0;
                        end
                    end
                    PH_C0, PH_C1:
                    begin
                        if ((phase_reg == PH_C0) ? tok_reg.v0 : tok_reg.v1)
                        begin
                            if (merge)
                            begin
                                held_reg <= voiced;
                            end
                            else
                            begin
                                held_reg <= mapped;
                                held_v_reg <= 1'b1;
                                dots_reg <= rel.dots;
                                ell_reg <= rel.ell;
                                if (rel.av)
                                begin
                                    ev0_reg <= rel.a;
                                    ev1_reg <= rel.b;
                                    ev_v_reg <= {rel.bv, 1'b1};
                                end
                                else
                                begin
                                    ev0_reg <= rel.b;
                                    ev_v_reg <= {1'b0, rel.bv};
                                end
                            end
                        end
                        phase_reg <= (phase_reg == PH_C0) ? PH_C1 : PH_FIN;
                    end
                    PH_FIN:
                    begin
                        if (tok_reg.last && !tok_reg.err)
                        begin
                            held_v_reg <= 1'b0;
                            dots_reg <= 2'd0;
                            ell_reg <= rel.ell;
                            if (rel.av)
                            begin
                                ev0_reg <= rel.a;
                                ev1_reg <= fl_cp;
                                ev_v_reg <= {fl_v, 1'b1};
                            end
                            else
                            begin
                                ev0_reg <= fl_cp;
                                ev_v_reg <= {1'b0, fl_v};
                            end
                        end
                        phase_reg <= PH_END;
                    end
                    PH_END:
                    begin
                        if (tok_reg.last)
                        begin
                            o_v_reg <= 1'b1;
                            o_last_reg <= 1'b1;
                            if (tok_reg.err || !stage_v_reg)
                            begin
                                o_byte_reg <= 8'h00;
                                o_user_reg <= {tok_reg.err, 2'b10};
                            end
                            else
                            begin
                                o_byte_reg <= stage_reg;
                                o_user_reg <= 3'b011;
                            end
                            held_reg <= '0;
                            held_v_reg <= 1'b0;
                            dots_reg <= 2'd0;
                            ell_reg <= 1'b0;
                            any_reg <= 1'b0;
                            sp_reg <= 1'b0;
                        end
                        else if (stage_v_reg)
                        begin
                            o_v_reg <= 1'b1;
                            o_last_reg <= 1'b0;
                            o_byte_reg <= stage_reg;
                            o_user_reg <= 3'b011;
                        end
                        stage_v_reg <= 1'b0;
                        cnt_reg <= 5'd0;
                        phase_reg <= PH_IDLE;
                    end
                    default:
                    begin
                        phase_reg <= PH_IDLE;
                    end
                endcase
            end
        end
    end

endmodule

// ===== hw/rtl/kana_text_normalizer_top.sv =====
// Top level of the kana text normalizer: front decoder, queue and back formatter.
//
// The slave channel takes one UTF-8 byte of a text per transfer, with tlast on
// the final byte of the text. The master channel gives the normalized UTF-8
// bytes; tuser carries byte_present, run_last and bad_utf8, and tlast marks the
// final transfer of the whole text. A text void through bad or truncated UTF-8
// ends with one transfer that has byte_present low and bad_utf8 high; bytes
// already sent for that text are to be dropped by the receiver.
// The front decodes one byte per cycle into a four-entry queue, while that queue
// is not full. The back takes one queued entry at a time through its idle, first
// codepoint, second codepoint, finish and end phases, plus a step per output byte
// and per whitespace codepoint it absorbs, and pops no new entry before it is done.
// When the receiver stalls, the output register holds and the back waits; the
// queue then fills and slave tready falls. Reset clears all text state and
// empties the queue.
module kana_text_normalizer_top import knt_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // in_byte
    input  logic       s_tlast,   // text_last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte
    output logic       m_tlast,   // text_end
    output logic [2:0] m_tuser    // byte_present, run_last, bad_utf8
);

`include "assert_macros.svh"

    logic push, full, pop, nonempty;
    tok_t push_tok, pop_tok;

    knt_front u_front (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .push(push), .push_tok(push_tok), .full(full)
    );

    knt_fifo u_fifo (
        .clk(clk), .rst_n(rst_n),
        .push(push), .push_tok(push_tok), .full(full),
        .pop(pop), .nonempty(nonempty), .pop_tok(pop_tok)
    );

    knt_back u_back (
        .clk(clk), .rst_n(rst_n),
        .nonempty(nonempty), .pop_tok(pop_tok), .pop(pop),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser)
    );

    `ASSERT_IMPLIES(a_end_is_run_last, m_tvalid && m_tlast, m_tuser[1],
        "text end without run end")
    `ASSERT_IMPLIES(a_bad_is_bare_end, m_tvalid && m_tuser[2],
        !m_tuser[0] && m_tlast, "bad flag off a bare end")
    `ASSERT_IMPLIES(a_bare_only_at_end, m_tvalid && !m_tuser[0],
        m_tlast && (m_tdata == 8'h00), "bare transfer inside a text")
    `ASSERT_IMPLIES(a_no_pop_empty, !nonempty, !pop, "queue read while empty")
    `ASSERT_NEXT(a_hold_on_stall, m_tvalid && !m_tready,
        m_tvalid && $stable({m_tdata, m_tuser, m_tlast}), "output changed while stalled")

endmodule

// ===== dv/kana_text_normalizer_top_tb.sv =====
// Self-checking testbench for the kana text normalizer: random and directed UTF-8 texts.
`timescale 1ns / 100ps

module kana_text_normalizer_top_tb;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic       run_last;
        logic       text_end;
        logic       bad;
    } out_beat_t;

    localparam int WATCHDOG_LIMIT = 20000;

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic [2:0] m_tuser;

    kana_text_normalizer_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    in_beat_t  pending_bytes[$];
    out_beat_t expected_bytes[$];
    int        mismatch_count;
    int        idle_cycles;
    bit        src_quiet;
    bit        sink_hold;
    bit        no_idle;
    bit        stim_done;

    // Predictor state.
    logic [20:0] acc;
    logic [1:0]  remaining;
    logic [20:0] held_cp;
    bit          held_ok;
    bit          wrote_any;
    bit          owe_space;
    int          dots;
    bit          ell_pend;
    bit          void_text;
    bit          in_seen;
    bit          in_owe_space;
    logic [7:0]  text_bytes[$];

    logic [15:0] half_width_map[56] = '{
        16'h30F2, 16'h30A1, 16'h30A3, 16'h30A5, 16'h30A7, 16'h30A9, 16'h30E3, 16'h30E5,
        16'h30E7, 16'h30C3, 16'h30FC, 16'h30A2, 16'h30A4, 16'h30A6, 16'h30A8, 16'h30AA,
        16'h30AB, 16'h30AD, 16'h30AF, 16'h30B1, 16'h30B3, 16'h30B5, 16'h30B7, 16'h30B9,
        16'h30BB, 16'h30BD, 16'h30BF, 16'h30C1, 16'h30C4, 16'h30C6, 16'h30C8, 16'h30CA,
        16'h30CB, 16'h30CC, 16'h30CD, 16'h30CE, 16'h30CF, 16'h30D2, 16'h30D5, 16'h30D8,
        16'h30DB, 16'h30DE, 16'h30DF, 16'h30E0, 16'h30E1, 16'h30E2, 16'h30E4, 16'h30E6,
        16'h30E8, 16'h30E9, 16'h30EA, 16'h30EB, 16'h30EC, 16'h30ED, 16'h30EF, 16'h30F3
    };

    function automatic bit is_blank(logic [20:0] c);
        return c == 21'h20 || c == 21'h09 || c == 21'h0A || c == 21'h0D;
    endfunction

    task automatic clear_text_state();
        acc = '0;
        remaining = '0;
        held_cp = '0;
        held_ok = 0;
        wrote_any = 0;
        owe_space = 0;
        dots = 0;
        ell_pend = 0;
        void_text = 0;
        in_seen = 0;
        in_owe_space = 0;
    endtask

    task automatic add_text_byte(logic [7:0] b);
        if (text_bytes.size() < 16)
            text_bytes = {text_bytes, b};
    endtask

    task automatic add_expected(out_beat_t r);
        expected_bytes = {expected_bytes, r};
    endtask

    task automatic encode_utf8(logic [20:0] cp);
        if (cp <= 21'h7F)
        begin
            add_text_byte(cp[7:0]);
        end
        else if (cp <= 21'h7FF)
        begin
            add_text_byte(8'hC0 | {3'd0, cp[10:6]});
            add_text_byte(8'h80 | {2'd0, cp[5:0]});
        end
        else if (cp <= 21'hFFFF)
        begin
            add_text_byte(8'hE0 | {4'd0, cp[15:12]});
            add_text_byte(8'h80 | {2'd0, cp[11:6]});
            add_text_byte(8'h80 | {2'd0, cp[5:0]});
        end
        else
        begin
            add_text_byte(8'hF0 | {5'd0, cp[20:18]});
            add_text_byte(8'h80 | {2'd0, cp[17:12]});
            add_text_byte(8'h80 | {2'd0, cp[11:6]});
            add_text_byte(8'h80 | {2'd0, cp[5:0]});
        end
    endtask

    task automatic write_cp(logic [20:0] c);
        if (is_blank(c))
        begin
            if (wrote_any)
                owe_space = 1;
        end
        else
        begin
            if (owe_space)
                add_text_byte(8'h20);
            owe_space = 0;
            encode_utf8(c);
            wrote_any = 1;
        end
    endtask

    task automatic flush_dot_run();
        if (dots == 2)
            write_cp(21'h2026);
        else if (dots == 1)
            write_cp(21'h2E);
        dots = 0;
    endtask

    task automatic punctuate(logic [20:0] c_in);
        logic [20:0] c;
        c = c_in;
        case (c)
            21'hFF01: c = 21'h21;
            21'hFF1F: c = 21'h3F;
            21'hFF0C, 21'hFF64: c = 21'h3001;
            21'hFF0E, 21'hFF61: c = 21'h3002;
            21'hFF62: c = 21'h300C;
            21'hFF63: c = 21'h300D;
            21'h3000: c = 21'h20;
            default: ;
        endcase
        if (c == 21'h2E)
        begin
            ell_pend = 0;
            dots++;
            if (dots >= 3)
            begin
                write_cp(21'h2026);
                dots = 0;
            end
        end
        else
        begin
            flush_dot_run();
            if (c == 21'h2026)
            begin
                if (!ell_pend)
                    write_cp(c);
                ell_pend = !ell_pend;
            end
            else
            begin
                ell_pend = 0;
                write_cp(c);
            end
        end
    endtask

    function automatic logic [20:0] apply_voicing(logic [20:0] k, logic [20:0] mark);
        bit h_row;
        h_row = k == 21'h30CF || k == 21'h30D2 || k == 21'h30D5 || k == 21'h30D8
                || k == 21'h30DB;
        if (mark == 21'h3099 || mark == 21'hFF9E)
        begin
            if (k == 21'h30A6)
                return 21'h30F4;
            if (k >= 21'h30AB && k <= 21'h30C1 && k[0])
                return k + 21'd1;
            if (k == 21'h30C4 || k == 21'h30C6 || k == 21'h30C8 || h_row)
                return k + 21'd1;
            if (k >= 21'h30EF && k <= 21'h30F2)
                return k + 21'd8;
            return k;
        end
        if (h_row)
            return k + 21'd2;
        return k;
    endfunction

    task automatic take_codepoint(logic [20:0] c_in);
        logic [20:0] c;
        logic [20:0] v;
        logic [20:0] d;
        c = c_in;
        d = c - 21'hFF66;
        if (c >= 21'h3041 && c <= 21'h3096)
            c = c + 21'h60;
        else if (c == 21'h309D)
            c = 21'h30FD;
        else if (c == 21'h309E)
            c = 21'h30FE;
        else if (c >= 21'hFF66 && c <= 21'hFF9D)
            c = {5'd0, half_width_map[d[5:0]]};
        if (held_ok && (c == 21'h3099 || c == 21'h309A || c == 21'hFF9E || c == 21'hFF9F))
        begin
            v = apply_voicing(held_cp, c);
            if (v != held_cp)
            begin
                held_cp = v;
                return;
            end
        end
        if (held_ok)
            punctuate(held_cp);
        held_cp = c;
        held_ok = 1;
    endtask

    task automatic decode_byte(logic [7:0] b);
        if (void_text)
            return;
        if (remaining != 0)
        begin
            acc = {acc[14:0], b[5:0]};
            remaining--;
            if (remaining == 0)
                take_codepoint(acc);
        end
        else if (!b[7])
            take_codepoint({13'd0, b});
        else if (b[7:5] == 3'b110)
        begin
            acc = {16'd0, b[4:0]};
            remaining = 2'd1;
        end
        else if (b[7:4] == 4'b1110)
        begin
            acc = {17'd0, b[3:0]};
            remaining = 2'd2;
        end
        else if (b[7:3] == 5'b11110)
        begin
            acc = {18'd0, b[2:0]};
            remaining = 2'd3;
        end
        else
            void_text = 1;
    endtask

    task automatic predict_text_byte(in_beat_t item);
        out_beat_t r;
        text_bytes.delete();
        if (is_blank({13'd0, item.data}))
        begin
            if (in_seen)
                in_owe_space = 1;
        end
        else
        begin
            if (in_owe_space)
                decode_byte(8'h20);
            in_owe_space = 0;
            decode_byte(item.data);
            in_seen = 1;
        end
        if (!item.last)
        begin
            if (void_text)
                return;
            foreach (text_bytes[k])
            begin
                r = '{text_bytes[k], 1'b1, k == text_bytes.size() - 1, 1'b0, 1'b0};
                add_expected(r);
            end
            return;
        end
        if (!void_text && remaining != 0)
            void_text = 1;
        if (!void_text)
        begin
            if (held_ok)
                punctuate(held_cp);
            held_ok = 0;
            flush_dot_run();
        end
        if (void_text || text_bytes.size() == 0)
        begin
            r = '{8'd0, 1'b0, 1'b1, 1'b1, void_text};
            add_expected(r);
        end
        else
        begin
            foreach (text_bytes[k])
            begin
                r = '{text_bytes[k], 1'b1, k == text_bytes.size() - 1,
                      k == text_bytes.size() - 1, 1'b0};
                add_expected(r);
            end
        end
        clear_text_state();
    endtask

    task automatic queue_byte(logic [7:0] b, bit last);
        in_beat_t item;
        item.data = b;
        item.last = last;
        pending_bytes = {pending_bytes, item};
    endtask

    task automatic queue_cp(logic [20:0] cp, bit last);
        text_bytes.delete();
        encode_utf8(cp);
        foreach (text_bytes[k])
            queue_byte(text_bytes[k], last && k == text_bytes.size() - 1);
    endtask

    function automatic logic [20:0] pick_cp();
        logic [20:0] c;
        case ($urandom_range(0, 11))
            0: c = 21'($urandom_range(21'h3041, 21'h309E));
            1: c = 21'($urandom_range(21'h30A1, 21'h30FE));
            2: c = 21'($urandom_range(21'hFF61, 21'hFF9F));
            3: c = ($urandom_range(0, 3) == 0) ? 21'h3099 : 21'h309A;
            4: c = ($urandom_range(0, 1) != 0) ? 21'hFF9E : 21'hFF9F;
            5: c = 21'h2E;
            6: c = 21'h2026;
            7: c = ($urandom_range(0, 1) != 0) ? 21'h3000 : 21'h20;
            8: c = ($urandom_range(0, 1) != 0) ?
                   21'($urandom_range(21'hFF01, 21'hFF1F)) : 21'hFF0E;
            9: c = 21'($urandom_range(21'h21, 21'h7E));
            10: c = 21'($urandom_range(21'h80, 21'h7FF));
            default: c = 21'($urandom_range(21'h10000, 21'h1FFFFF));
        endcase
        return c;
    endfunction

    task automatic queue_random_text(int n_cp);
        for (int i = 0; i < n_cp; i++)
            queue_cp(pick_cp(), i == n_cp - 1);
    endtask

    task automatic queue_noise_text(int n);
        for (int i = 0; i < n; i++)
            queue_byte(8'($urandom_range(0, 255)), i == n - 1);
    endtask

    task automatic wait_drained();
        while (pending_bytes.size() != 0 || expected_bytes.size() != 0)
            @(posedge clk);
    endtask

    initial clk = 1'b0;

    always #5 clk = ~clk;

    // Driver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tlast <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_text_byte('{s_tdata, s_tlast});
                void'(pending_bytes.pop_front());
            end
            if ((s_tvalid && !s_tready) ||
                (pending_bytes.size() > 0 && !src_quiet &&
                 (no_idle || $urandom_range(0, 99) >= 6)))
            begin
                s_tvalid <= 1'b1;
                s_tdata <= pending_bytes[0].data;
                s_tlast <= pending_bytes[0].last;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor and receiver.
    always @(posedge clk or negedge rst_n)
    begin
        out_beat_t got;
        out_beat_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            idle_cycles <= 0;
        end
        else
        begin
            m_tready <= !sink_hold && (no_idle || $urandom_range(0, 99) >= 6);
            if (m_tvalid && m_tready)
            begin
                got = '{m_tdata, m_tuser[0], m_tuser[1], m_tlast, m_tuser[2]};
                if (expected_bytes.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected transfer: %p", got);
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (got !== want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: expected %p actual %p", want, got);
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("kana_text_normalizer_top_tb: errors");
            $finish;
        end
    end

    initial
    begin
        string spaced;
        string dotted;
        src_quiet = 0;
        sink_hold = 0;
        no_idle = 0;
        stim_done = 0;
        mismatch_count = 0;
        clear_text_state();
        spaced = "  a \t\r\n b  ";
        dotted = ".....x..";
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed texts: kana mapping, voicing, punctuation, dots, spaces, errors.
        queue_byte(8'h00, 1);
        queue_byte(8'h20, 1);
        foreach (spaced[i])
            queue_byte(spaced[i], i == spaced.len() - 1);
        queue_cp(21'h304B, 0);
        queue_cp(21'h3099, 0);
        queue_cp(21'hFF8A, 0);
        queue_cp(21'hFF9F, 0);
        queue_cp(21'h309D, 0);
        queue_cp(21'hFF01, 0);
        queue_cp(21'h3000, 0);
        queue_cp(21'hFF61, 1);
        foreach (dotted[i])
            queue_byte(dotted[i], 0);
        queue_cp(21'h2026, 0);
        queue_cp(21'h2026, 0);
        queue_cp(21'h2026, 1);
        queue_byte(8'hFF, 0);
        queue_byte(8'h41, 1);
        queue_byte(8'hE3, 1);
        queue_byte(8'h80, 1);
        queue_cp(21'h1FFFFF, 1);
        wait_drained();

        // The receiver holds off while a random text is sent, then lets the results drain.
        sink_hold = 1;
        queue_random_text(8);
        repeat (300) @(posedge clk);
        sink_hold = 0;
        wait_drained();

        no_idle = 1;
        for (int t = 0; t < 6; t++)
            queue_random_text($urandom_range(1, 6));
        wait_drained();
        no_idle = 0;

        while (pending_bytes.size() < 90)
        begin
            if ($urandom_range(0, 9) == 0)
                queue_noise_text($urandom_range(1, 6));
            else
                queue_random_text($urandom_range(1, 8));
        end
        wait_drained();
        repeat (50) @(posedge clk);
        if (mismatch_count == 0 && expected_bytes.size() == 0)
            $display("kana_text_normalizer_top_tb: clean");
        else
            $display("kana_text_normalizer_top_tb: errors");
        $finish;
    end

endmodule
